>>> hdl/kmt_pkg.sv
`default_nettype none

package kmt_pkg;

    // Operation codes on the input word.
    localparam logic [1:0] FUNC_OPEN    = 2'd0;
    localparam logic [1:0] FUNC_ACQUIRE = 2'd1;
    localparam logic [1:0] FUNC_RELEASE = 2'd2;

    // Status codes on the result word.
    localparam logic [1:0] STAT_OK         = 2'd0;
    localparam logic [1:0] STAT_TABLE_FULL = 2'd1;
    localparam logic [1:0] STAT_QUEUE_FULL = 2'd2;

    // The handle count saturates at its all-ones value.
    localparam int unsigned HCOUNT_W = 5;
    localparam logic [HCOUNT_W-1:0] HCOUNT_MAX = '1;

    typedef struct packed {
        logic [1:0]  func;
        logic [31:0] lock_key;
        logic [3:0]  slot;
        logic [3:0]  task_req;
    } in_word_t;

    typedef struct packed {
        logic [1:0] status;
        logic [3:0] slot_out;
        logic       granted;
        logic       woken_valid;
        logic [3:0] woken_task;
    } out_word_t;

    typedef enum logic [1:0] {
        CMD_OPEN,
        CMD_ACQUIRE,
        CMD_RELEASE,
        CMD_NOP
    } cmd_kind_t;

    typedef struct packed {
        cmd_kind_t   kind;
        logic [31:0] lock_key;
        logic [3:0]  slot;
        logic [3:0]  task_req;
    } cmd_t;

endpackage

`default_nettype wire

>>> hdl/kmt_ram.sv
`default_nettype none

module kmt_ram #(
    parameter int unsigned WIDTH = 8,
    parameter int unsigned DEPTH = 16
) (
    input  wire logic                     aclk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // One write port and one registered read port.
    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

`default_nettype wire

>>> hdl/kmt_front.sv
`default_nettype none

module kmt_front
    import kmt_pkg::*;
#(
    parameter int unsigned LOCK_SLOTS = 16
) (
    input  wire logic     aclk,
    input  wire logic     aresetn,
    input  wire logic     s_valid,
    output logic          s_ready,
    input  wire in_word_t s_data,
    output logic          q_valid,
    input  wire logic     q_ready,
    output cmd_t          q_cmd
);

    cmd_t       ent_reg [2];
    logic       wr_ptr_reg;
    logic       rd_ptr_reg;
    logic [1:0] cnt_reg;
    cmd_t       cmd_in;
    logic       push;
    logic       pop;

    // Classify the incoming word. Out-of-range slots and the unused code
    // become a no-op that still yields an all-zero result.
    always_comb begin
        cmd_in.lock_key = s_data.lock_key;
        cmd_in.slot     = s_data.slot;
        cmd_in.task_req = s_data.task_req;
        unique case (s_data.func)
            FUNC_OPEN: begin
                cmd_in.kind = CMD_OPEN;
            end
            FUNC_ACQUIRE: begin
                cmd_in.kind = (32'(s_data.slot) < LOCK_SLOTS) ? CMD_ACQUIRE : CMD_NOP;
            end
            FUNC_RELEASE: begin
                cmd_in.kind = (32'(s_data.slot) < LOCK_SLOTS) ? CMD_RELEASE : CMD_NOP;
            end
            default: begin
                cmd_in.kind = CMD_NOP;
            end
        endcase
    end

    assign s_ready = (cnt_reg != 2'd2);
    assign push    = s_valid && s_ready;
    assign q_valid = (cnt_reg != 2'd0);
    assign pop     = q_valid && q_ready;
    assign q_cmd   = ent_reg[rd_ptr_reg];

    // Two-entry queue between the front and the back.
    always_ff @(posedge aclk) begin
        if (push) begin
            ent_reg[wr_ptr_reg] <= cmd_in;
        end
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            cnt_reg    <= 2'd0;
        end else begin
            if (push) begin
                wr_ptr_reg <= ~wr_ptr_reg;
            end
            if (pop) begin
                rd_ptr_reg <= ~rd_ptr_reg;
            end
            if (push && !pop) begin
                cnt_reg <= cnt_reg + 2'd1;
            end else if (pop && !push) begin
                cnt_reg <= cnt_reg - 2'd1;
            end
        end
    end

    a_cnt_range: assert property (@(posedge aclk) disable iff (!aresetn)
        cnt_reg != 2'd3)
        else $error("queue count out of range");

    a_cnt_grow: assert property (@(posedge aclk) disable iff (!aresetn)
        (push && !pop) |=> cnt_reg == 2'($past(cnt_reg) + 2'd1))
        else $error("queue count did not grow on push");

    a_ptr_gap: assert property (@(posedge aclk) disable iff (!aresetn)
        (cnt_reg == 2'd0 || cnt_reg == 2'd2) |-> wr_ptr_reg == rd_ptr_reg)
        else $error("queue pointers disagree with count");

endmodule

`default_nettype wire

>>> hdl/kmt_back.sv
`default_nettype none

module kmt_back
    import kmt_pkg::*;
#(
    parameter int unsigned LOCK_SLOTS  = 16,
    parameter int unsigned MAX_WAITERS = 16
) (
    input  wire logic aclk,
    input  wire logic aresetn,
    input  wire logic q_valid,
    output logic      q_ready,
    input  wire cmd_t q_cmd,
    output logic      m_valid,
    input  wire logic m_ready,
    output out_word_t m_data
);

    localparam int unsigned SW  = $clog2(LOCK_SLOTS);
    localparam int unsigned HW  = (MAX_WAITERS > 1) ? $clog2(MAX_WAITERS) : 1;
    localparam int unsigned QCW = $clog2(MAX_WAITERS + 1);
    localparam int unsigned PW  = QCW + 1;
    localparam int unsigned WAW = $clog2(LOCK_SLOTS * MAX_WAITERS);

    typedef struct packed {
        logic [HCOUNT_W-1:0] hcount;
        logic                locked;
        logic [HW-1:0]       head;
        logic [QCW-1:0]      qcount;
    } meta_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SCAN,
        S_OPEN_WR,
        S_READ,
        S_EXEC,
        S_WAKE,
        S_DONE
    } state_t;

    state_t          state_reg;
    cmd_t            cmd_reg;
    logic [SW:0]     idx_reg;
    logic            chk_v_reg;
    logic [SW-1:0]   chk_idx_reg;
    logic            rd_vld_reg;
    logic            found_reg;
    logic [SW-1:0]   match_idx_reg;
    meta_t           match_meta_reg;
    logic            free_reg;
    logic [SW-1:0]   free_idx_reg;
    meta_t           hold_meta_reg;
    out_word_t       res_reg;
    out_word_t       m_data_reg;
    logic            m_valid_reg;
    logic [LOCK_SLOTS-1:0] vld_reg;

    logic [SW-1:0]   slot_idx;
    logic [SW-1:0]   meta_raddr;
    logic            meta_we;
    logic [SW-1:0]   meta_waddr;
    meta_t           meta_wdata;
    logic [$bits(meta_t)-1:0] meta_q;
    meta_t           meta_rd;
    logic            key_we;
    logic [31:0]     key_q;
    logic            wait_we;
    logic [WAW-1:0]  wait_waddr;
    logic [WAW-1:0]  wait_raddr;
    logic [3:0]      wait_q;
    logic [PW-1:0]   tail_sum;
    logic [HW-1:0]   tail_pos;
    logic [PW-1:0]   head_sum;
    logic [HW-1:0]   head_inc;
    logic            out_free;
    logic            chk_match;
    logic            chk_free;

    assign slot_idx = SW'(cmd_reg.slot);
    assign meta_rd  = rd_vld_reg ? meta_t'(meta_q) : '0;
    assign out_free = !m_valid_reg || m_ready;
    assign q_ready  = (state_reg == S_IDLE);
    assign m_valid  = m_valid_reg;
    assign m_data   = m_data_reg;

    // Scan checks for the slot whose data has just come back.
    assign chk_match = chk_v_reg && (meta_rd.hcount != '0) && (key_q == cmd_reg.lock_key);
    assign chk_free  = chk_v_reg && (meta_rd.hcount == '0) && (chk_idx_reg != '0);

    // Ring positions of the queue tail and of the slot after the head.
    always_comb begin
        tail_sum = PW'(meta_rd.head) + PW'(meta_rd.qcount);
        if (tail_sum >= PW'(MAX_WAITERS)) begin
            tail_sum = tail_sum - PW'(MAX_WAITERS);
        end
        tail_pos = HW'(tail_sum);
        head_sum = PW'(hold_meta_reg.head) + PW'(1);
        if (head_sum >= PW'(MAX_WAITERS)) begin
            head_sum = head_sum - PW'(MAX_WAITERS);
        end
        head_inc = HW'(head_sum);
    end

    assign wait_waddr = WAW'(WAW'(slot_idx) * WAW'(MAX_WAITERS) + WAW'(tail_pos));
    assign wait_raddr = WAW'(WAW'(slot_idx) * WAW'(MAX_WAITERS) + WAW'(meta_rd.head));

    // Memory port control for each step of the sequencer.
    always_comb begin
        meta_raddr = (state_reg == S_SCAN) ? idx_reg[SW-1:0] : slot_idx;
        meta_we    = 1'b0;
        meta_waddr = slot_idx;
        meta_wdata = meta_rd;
        key_we     = 1'b0;
        wait_we    = 1'b0;
        unique case (state_reg)
            S_OPEN_WR: begin
                if (found_reg) begin
                    meta_we    = 1'b1;
                    meta_waddr = match_idx_reg;
                    meta_wdata = match_meta_reg;
                    if (match_meta_reg.hcount != HCOUNT_MAX) begin
                        meta_wdata.hcount = match_meta_reg.hcount + HCOUNT_W'(1);
                    end
                end else if (free_reg) begin
                    meta_we           = 1'b1;
                    key_we            = 1'b1;
                    meta_waddr        = free_idx_reg;
                    meta_wdata        = '0;
                    meta_wdata.hcount = HCOUNT_W'(1);
                end
            end
            S_EXEC: begin
                if (cmd_reg.kind == CMD_ACQUIRE) begin
                    if (!meta_rd.locked) begin
                        meta_we           = 1'b1;
                        meta_wdata.locked = 1'b1;
                    end else if (32'(meta_rd.qcount) < MAX_WAITERS) begin
                        meta_we           = 1'b1;
                        wait_we           = 1'b1;
                        meta_wdata.qcount = meta_rd.qcount + QCW'(1);
                    end
                end else if (meta_rd.qcount == '0) begin
                    meta_we           = 1'b1;
                    meta_wdata.locked = 1'b0;
                end
            end
            S_WAKE: begin
                meta_we           = 1'b1;
                meta_wdata        = hold_meta_reg;
                meta_wdata.head   = head_inc;
                meta_wdata.qcount = hold_meta_reg.qcount - QCW'(1);
            end
            default: begin
            end
        endcase
    end

    kmt_ram #(.WIDTH($bits(meta_t)), .DEPTH(LOCK_SLOTS)) u_meta_ram (
        .aclk  (aclk),
        .we    (meta_we),
        .waddr (meta_waddr),
        .wdata (meta_wdata),
        .raddr (meta_raddr),
        .rdata (meta_q)
    );

    kmt_ram #(.WIDTH(32), .DEPTH(LOCK_SLOTS)) u_key_ram (
        .aclk  (aclk),
        .we    (key_we),
        .waddr (free_idx_reg),
        .wdata (cmd_reg.lock_key),
        .raddr (meta_raddr),
        .rdata (key_q)
    );

    kmt_ram #(.WIDTH(4), .DEPTH(LOCK_SLOTS * MAX_WAITERS)) u_wait_ram (
        .aclk  (aclk),
        .we    (wait_we),
        .waddr (wait_waddr),
        .wdata (cmd_reg.task_req),
        .raddr (wait_raddr),
        .rdata (wait_q)
    );

    // Sequencer: state, scan bookkeeping and the result registers.
    always_ff @(posedge aclk) begin
        rd_vld_reg <= vld_reg[meta_raddr];
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            m_valid_reg <= 1'b0;
            vld_reg     <= '0;
            chk_v_reg   <= 1'b0;
        end else begin
            if (meta_we) begin
                vld_reg[meta_waddr] <= 1'b1;
            end
            // A new word in the done state replaces the one being taken.
            if (m_valid_reg && m_ready && state_reg != S_DONE) begin
                m_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                S_IDLE: begin
                    if (q_valid) begin
                        cmd_reg   <= q_cmd;
                        res_reg   <= '0;
                        idx_reg   <= '0;
                        chk_v_reg <= 1'b0;
                        found_reg <= 1'b0;
                        free_reg  <= 1'b0;
                        unique case (q_cmd.kind)
                            CMD_OPEN:    state_reg <= S_SCAN;
                            CMD_ACQUIRE: state_reg <= S_READ;
                            CMD_RELEASE: state_reg <= S_READ;
                            default:     state_reg <= S_DONE;
                        endcase
                    end
                end
                S_SCAN: begin
                    if (chk_match && !found_reg) begin
                        found_reg      <= 1'b1;
                        match_idx_reg  <= chk_idx_reg;
                        match_meta_reg <= meta_rd;
                    end
                    if (chk_free && !free_reg) begin
                        free_reg     <= 1'b1;
                        free_idx_reg <= chk_idx_reg;
                    end
                    if (32'(idx_reg) < LOCK_SLOTS) begin
                        chk_v_reg   <= 1'b1;
                        chk_idx_reg <= idx_reg[SW-1:0];
                        idx_reg     <= idx_reg + (SW+1)'(1);
                    end else begin
                        chk_v_reg <= 1'b0;
                        state_reg <= S_OPEN_WR;
                    end
                end
                S_OPEN_WR: begin
                    if (found_reg) begin
                        res_reg.slot_out <= 4'(match_idx_reg);
                    end else if (free_reg) begin
                        res_reg.slot_out <= 4'(free_idx_reg);
                    end else begin
                        res_reg.status <= STAT_TABLE_FULL;
                    end
                    state_reg <= S_DONE;
                end
                S_READ: begin
                    state_reg <= S_EXEC;
                end
                S_EXEC: begin
                    state_reg <= S_DONE;
                    if (cmd_reg.kind == CMD_ACQUIRE) begin
                        if (!meta_rd.locked) begin
                            res_reg.granted <= 1'b1;
                        end else if (32'(meta_rd.qcount) >= MAX_WAITERS) begin
                            res_reg.status <= STAT_QUEUE_FULL;
                        end
                    end else if (meta_rd.qcount != '0) begin
                        hold_meta_reg <= meta_rd;
                        state_reg     <= S_WAKE;
                    end
                end
                S_WAKE: begin
                    res_reg.woken_valid <= 1'b1;
                    res_reg.woken_task  <= wait_q;
                    state_reg           <= S_DONE;
                end
                S_DONE: begin
                    if (out_free) begin
                        m_data_reg  <= res_reg;
                        m_valid_reg <= 1'b1;
                        state_reg   <= S_IDLE;
                    end
                end
                default: begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    a_full_only_open: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_DONE && res_reg.status == STAT_TABLE_FULL)
            |-> cmd_reg.kind == CMD_OPEN)
        else $error("table full reported for a non-open request");

    a_wake_only_release: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_DONE && res_reg.woken_valid) |-> cmd_reg.kind == CMD_RELEASE)
        else $error("wake reported for a non-release request");

    a_grant_excl: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == S_DONE |-> !(res_reg.granted && res_reg.woken_valid))
        else $error("grant and wake in one result");

    a_exec_addr: assert property (@(posedge aclk) disable iff (!aresetn)
        (meta_we && state_reg != S_OPEN_WR) |-> meta_waddr == slot_idx)
        else $error("slot state written at a foreign slot");

endmodule

`default_nettype wire

>>> hdl/keyed_mutex_table_with_waiters.sv
// Steps: acquire and release without a waiter go through read, execute and done;
// release with a waiter adds a wake step; open scans every slot (one slot key read per
// cycle in the scan), then writes and finishes. Flow: one word at a time in the back end,
// which takes the next word only after handing on the result; a two-word queue
// lets the input side take words while the back end works.
// Reset: synchronous, active low; clears the control state and the per-slot valid
// bits at once, with no clearing pass.
`default_nettype none

module keyed_mutex_table_with_waiters
    import kmt_pkg::*;
#(
    parameter int unsigned LOCK_SLOTS  = 16,
    parameter int unsigned MAX_WAITERS = 16
) (
    input  wire logic     aclk,
    input  wire logic     aresetn,
    input  wire logic     s_valid,
    output logic          s_ready,
    input  wire in_word_t s_data,
    output logic          m_valid,
    input  wire logic     m_ready,
    output out_word_t     m_data
);

    logic q_valid;
    logic q_ready;
    cmd_t q_cmd;

    kmt_front #(.LOCK_SLOTS(LOCK_SLOTS)) u_front (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .q_valid (q_valid),
        .q_ready (q_ready),
        .q_cmd   (q_cmd)
    );

    kmt_back #(.LOCK_SLOTS(LOCK_SLOTS), .MAX_WAITERS(MAX_WAITERS)) u_back (
        .aclk    (aclk),
        .aresetn (aresetn),
        .q_valid (q_valid),
        .q_ready (q_ready),
        .q_cmd   (q_cmd),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

endmodule

`default_nettype wire

>>> sim/kmt_checker.sv
`timescale 1ns / 100ps
`default_nettype none

module kmt_checker
    import kmt_pkg::*;
(
    input  wire logic      aclk,
    input  wire logic      aresetn,
    input  wire logic      s_valid,
    input  wire logic      s_ready,
    input  wire in_word_t  s_data,
    input  wire logic      m_valid,
    input  wire logic      m_ready,
    input  wire out_word_t m_data,
    output int             fail_count,
    output int             pending_words
);

    localparam int NSLOTS = 16;
    localparam int NWAIT  = 16;

    // Shadow copy of the lock table.
    logic [31:0] key_tab  [NSLOTS];
    logic [4:0]  hcnt_tab [NSLOTS];
    logic        held_tab [NSLOTS];
    logic [3:0]  waitq    [NSLOTS][NWAIT];
    logic [3:0]  qhead    [NSLOTS];
    int          qcnt     [NSLOTS];

    out_word_t expected_words[$];

    // Apply one request to the shadow table and return the result word.
    function automatic out_word_t lock_table_update(in_word_t w);
        out_word_t r;
        logic      done;
        int        s;
        r = '0;
        done = 1'b0;
        s = w.slot;
        if (w.func == FUNC_OPEN) begin
            for (int i = 0; i < NSLOTS; i++) begin
                if (!done && hcnt_tab[i] != 0 && key_tab[i] == w.lock_key) begin
                    if (hcnt_tab[i] != HCOUNT_MAX) hcnt_tab[i]++;
                    r.slot_out = i[3:0];
                    done = 1'b1;
                end
            end
            for (int i = 1; i < NSLOTS; i++) begin
                if (!done && hcnt_tab[i] == 0) begin
                    hcnt_tab[i] = 5'd1;
                    held_tab[i] = 1'b0;
                    qhead[i] = '0;
                    qcnt[i] = 0;
                    key_tab[i] = w.lock_key;
                    r.slot_out = i[3:0];
                    done = 1'b1;
                end
            end
            if (!done) r.status = STAT_TABLE_FULL;
        end else if (w.func == FUNC_ACQUIRE) begin
            if (!held_tab[s]) begin
                held_tab[s] = 1'b1;
                r.granted = 1'b1;
            end else if (qcnt[s] < NWAIT) begin
                waitq[s][4'(qhead[s] + qcnt[s])] = w.task_req;
                qcnt[s]++;
            end else begin
                r.status = STAT_QUEUE_FULL;
            end
        end else if (w.func == FUNC_RELEASE) begin
            if (qcnt[s] > 0) begin
                r.woken_task = waitq[s][qhead[s]];
                r.woken_valid = 1'b1;
                qhead[s] = qhead[s] + 4'd1;
                qcnt[s]--;
            end else begin
                held_tab[s] = 1'b0;
            end
        end
        return r;
    endfunction

    // Predict on each accepted input word, compare on each accepted result word.
    always @(posedge aclk) begin
        out_word_t want;
        if (!aresetn) begin
            for (int i = 0; i < NSLOTS; i++) begin
                key_tab[i] = '0;
                hcnt_tab[i] = '0;
                held_tab[i] = 1'b0;
                qhead[i] = '0;
                qcnt[i] = 0;
            end
            expected_words.delete();
            fail_count = 0;
        end else begin
            if (m_valid && m_ready) begin
                if (expected_words.size() == 0) begin
                    fail_count++;
                    if (fail_count <= 10)
                        $display("Unexpected result word %h", m_data);
                end else begin
                    want = expected_words.pop_front();
                    if (want.status !== m_data.status || want.slot_out !== m_data.slot_out
                        || want.granted !== m_data.granted
                        || want.woken_valid !== m_data.woken_valid
                        || want.woken_task !== m_data.woken_task) begin
                        fail_count++;
                        if (fail_count <= 10)
                            $display("Mismatch: expected st=%0d slot=%0d gr=%0d wv=%0d wt=%0d, got st=%0d slot=%0d gr=%0d wv=%0d wt=%0d",
                                     want.status, want.slot_out, want.granted,
                                     want.woken_valid, want.woken_task,
                                     m_data.status, m_data.slot_out, m_data.granted,
                                     m_data.woken_valid, m_data.woken_task);
                    end
                end
            end
            if (s_valid && s_ready)
                expected_words.push_back(lock_table_update(s_data));
        end
        pending_words = expected_words.size();
    end

endmodule

`default_nettype wire

>>> sim/keyed_mutex_table_with_waiters_tb.sv
`timescale 1ns / 100ps
`default_nettype none

module keyed_mutex_table_with_waiters_tb;
    import kmt_pkg::*;

    logic      aclk = 1'b0;
    logic      aresetn = 1'b0;
    logic      s_valid = 1'b0;
    logic      s_ready;
    in_word_t  s_data = '0;
    logic      m_valid;
    logic      m_ready = 1'b0;
    out_word_t m_data;
    int        fail_count;
    int        pending_words;

    // Receiver behavior: idle percentage and a long hold-off request.
    int        sink_idle_pct = 38;
    logic      hold_request = 1'b0;
    logic      hold_active = 1'b0;

    // A small pool of keys so that opens hit existing slots often.
    logic [31:0] key_pool[8];

    always #5 aclk = ~aclk;

    keyed_mutex_table_with_waiters u_dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

    kmt_checker u_check (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_data        (s_data),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_data        (m_data),
        .fail_count    (fail_count),
        .pending_words (pending_words)
    );

    // Global time limit.
    initial begin
        #20ms;
        $display("*** FAILED ***");
        $finish;
    end

    // Receiver: random ready, with one long counted hold-off on request.
    initial begin
        forever begin
            @(negedge aclk);
            if (hold_request && !hold_active) begin
                hold_active = 1'b1;
                m_ready <= 1'b0;
                repeat (300) @(negedge aclk);
            end
            m_ready <= ($urandom_range(99) >= sink_idle_pct);
        end
    end

    // Present one word and wait for its acceptance.
    task automatic send_word(logic [1:0] f, logic [31:0] k, logic [3:0] sl, logic [3:0] tk,
                             int idle_pct);
        while ($urandom_range(99) < idle_pct) begin
            s_valid <= 1'b0;
            @(negedge aclk);
        end
        s_valid <= 1'b1;
        s_data <= '{func: f, lock_key: k, slot: sl, task_req: tk};
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        @(negedge aclk);
    endtask

    task automatic send_random(int idle_pct);
        int sel;
        logic [1:0] f;
        logic [31:0] k;
        sel = $urandom_range(99);
        if (sel < 22) f = FUNC_OPEN;
        else if (sel < 60) f = FUNC_ACQUIRE;
        else if (sel < 96) f = FUNC_RELEASE;
        else f = 2'd3;
        k = ($urandom_range(3) == 0) ? $urandom() : key_pool[$urandom_range(7)];
        send_word(f, k, ($urandom_range(3) == 0) ? 4'($urandom()) : 4'($urandom_range(4)),
                  4'($urandom()), idle_pct);
    endtask

    initial begin
        for (int i = 0; i < 8; i++) key_pool[i] = $urandom();
        key_pool[0] = 32'h0;
        key_pool[1] = 32'hFFFF_FFFF;
        repeat (9) @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // Directed: opens with extreme keys, repeat opens, lock and queue on slot 1.
        send_word(FUNC_OPEN, 32'h0, 4'd0, 4'd0, 0);
        send_word(FUNC_OPEN, 32'hFFFF_FFFF, 4'd0, 4'd15, 0);
        send_word(FUNC_OPEN, 32'h0, 4'd0, 4'd0, 0);
        send_word(FUNC_ACQUIRE, 32'h0, 4'd1, 4'd3, 0);
        send_word(FUNC_ACQUIRE, 32'h0, 4'd1, 4'd15, 0);
        send_word(FUNC_ACQUIRE, 32'h0, 4'd1, 4'd0, 0);
        send_word(FUNC_RELEASE, 32'h0, 4'd1, 4'd0, 0);
        send_word(FUNC_RELEASE, 32'h0, 4'd1, 4'd0, 0);
        send_word(FUNC_RELEASE, 32'h0, 4'd1, 4'd0, 0);
        send_word(FUNC_RELEASE, 32'h0, 4'd1, 4'd0, 0);
        // Unopened slots, including slot 0 and slot 15.
        send_word(FUNC_ACQUIRE, 32'h0, 4'd15, 4'd7, 0);
        send_word(FUNC_RELEASE, 32'h0, 4'd15, 4'd7, 0);
        send_word(FUNC_ACQUIRE, 32'h0, 4'd0, 4'd9, 0);
        send_word(2'd3, 32'hFFFF_FFFF, 4'd15, 4'd15, 0);
        // Fill the table until it reports full.
        for (int i = 0; i < 15; i++)
            send_word(FUNC_OPEN, 32'h1000 + i, 4'd0, 4'd0, 0);
        // Overflow one waiter queue.
        for (int i = 0; i < 18; i++)
            send_word(FUNC_ACQUIRE, 32'h0, 4'd2, 4'(i), 0);
        // Saturate one handle count.
        for (int i = 0; i < 33; i++)
            send_word(FUNC_OPEN, 32'hFFFF_FFFF, 4'd0, 4'd0, 0);

        // Long stretch with no idling on either side, receiver held off midway.
        sink_idle_pct = 0;
        for (int i = 0; i < 250; i++) begin
            if (i == 50) hold_request = 1'b1;
            send_random(0);
        end
        hold_request = 1'b0;
        sink_idle_pct = 38;
        for (int i = 0; i < 1300; i++)
            send_random(38);
        s_valid <= 1'b0;

        // Drain, then allow for the slowest operation.
        while (pending_words != 0) @(negedge aclk);
        repeat (50) @(negedge aclk);
        if (fail_count == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule

`default_nettype wire

>>> filelist.f
hdl/kmt_pkg.sv
hdl/kmt_ram.sv
hdl/kmt_front.sv
hdl/kmt_back.sv
hdl/keyed_mutex_table_with_waiters.sv
sim/kmt_checker.sv
sim/keyed_mutex_table_with_waiters_tb.sv
